>>> design/nfa_regex_full_match_unit_defines.svh
// assertion macros for the nfa matcher
`ifndef NFA_REGEX_FULL_MATCH_UNIT_DEFINES_SVH
`define NFA_REGEX_FULL_MATCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NFA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define NFA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define NFA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define NFA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> design/nfa_pkg.sv
package nfa_pkg;
    localparam int NODE_SLOTS_DEF  = 32;
    localparam int TRANS_SLOTS_DEF = 64;
    localparam int NODE_W = 5;
    localparam int SLOT_W = 6;
    localparam int CP_W   = 21;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_START = 2'd1,
        ACT_FEED  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic CFG_START  = 1'b0;
    localparam logic CFG_ACCEPT = 1'b1;

    typedef struct packed {
        logic [1:0]        action;
        logic [SLOT_W-1:0] slot_index;
        logic              entry_valid;
        logic              eps_flag;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] target_node;
        logic [CP_W-1:0]   range_low;
        logic [CP_W-1:0]   range_high;
        logic [CP_W-1:0]   codepoint;
    } in_word_t;

    typedef struct packed {
        logic accepted;
        logic alive;
    } out_word_t;

    // one table row as stored in ram, valid bit kept apart
    typedef struct packed {
        logic              eps_flag;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [CP_W-1:0]   lo;
        logic [CP_W-1:0]   hi;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;    // capture input word
        logic write_ent;  // write table entry from captured word
        logic seed_start; // set first set to start node bit
        logic clear_acc;  // clear accumulation set
        logic step;       // process one table entry
        logic commit_adv; // active set <= accumulated advance set
        logic commit_clo; // active set <= closure accumulated set
        logic load_out;   // register result
    } cmd_t;

    typedef struct packed {
        logic last_slot; // scan pointer at last entry
        logic changed;   // closure round added a node
    } sts_t;
endpackage

>>> design/nfa_ctrl.sv
`include "nfa_regex_full_match_unit_defines.svh"
module nfa_ctrl
    import nfa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic [1:0] s_action,
    output logic      m_valid,
    input  logic      m_ready,
    input  sts_t      sts,
    output cmd_t      cmd
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DISP = 5'b00010,
        ST_ADV  = 5'b00100,
        ST_CLO  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic [1:0] act_reg, act_next;

    assign m_valid = m_valid_reg;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        act_next     = act_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    act_next    = s_action;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                cmd.clear_acc = 1'b1;
                unique case (act_reg)
                    ACT_WRITE: begin
                        cmd.write_ent = 1'b1;
                        state_next    = ST_OUT;
                    end
                    ACT_START: begin
                        cmd.seed_start = 1'b1;
                        state_next     = ST_CLO;
                    end
                    ACT_FEED: state_next = ST_ADV;
                    default:  state_next = ST_OUT;
                endcase
            end
            ST_ADV: begin
                cmd.step = 1'b1;
                if (sts.last_slot) begin
                    cmd.commit_adv = 1'b1;
                    state_next     = ST_CLO;
                end
            end
            ST_CLO: begin
                cmd.step = 1'b1;
                if (sts.last_slot) begin
                    cmd.commit_clo = 1'b1;
                    if (!sts.changed) begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            act_reg     <= ACT_WRITE;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            act_reg     <= act_next;
        end
    end

    `NFA_ASSERT_NEXT(a_out_held, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `NFA_ASSERT_IMPL(a_busy, aclk, aresetn, state_reg != ST_IDLE, !s_ready, "ready in busy")
    `NFA_ASSERT_IMPL(a_one_commit, aclk, aresetn, cmd.commit_adv, !cmd.commit_clo, "two commits")
endmodule

>>> design/nfa_dp.sv
module nfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

module nfa_dp
    import nfa_pkg::*;
#(
    parameter int NODE_SLOTS  = NODE_SLOTS_DEF,
    parameter int TRANS_SLOTS = TRANS_SLOTS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  in_word_t        s_data,
    input  logic [NODE_W-1:0] start_node,
    input  logic [NODE_W-1:0] accept_node,
    input  cmd_t            cmd,
    output sts_t            sts,
    output out_word_t       m_data
);
    localparam int PW = (TRANS_SLOTS > 1) ? $clog2(TRANS_SLOTS) : 1;

    // rows in ram with registered read, valid bits in flip-flops
    logic [TRANS_SLOTS-1:0] ent_valid_reg;
    entry_t ent_wdata, ent_rdata;

    in_word_t in_reg;
    logic [NODE_SLOTS-1:0] act_reg, acc_reg, acc_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic          chg_reg, chg_next;
    logic          closing_reg;
    out_word_t     out_reg;
    logic          wr_en;
    logic [PW-1:0] wr_slot;

    function automatic logic [NODE_SLOTS-1:0] bit_of(input logic [NODE_W-1:0] n);
        logic [NODE_SLOTS-1:0] r;
        r = '0;
        if (32'(n) < NODE_SLOTS) r[n] = 1'b1;
        return r;
    endfunction

    logic [NODE_SLOTS-1:0] src_bit, dst_bit;
    logic hit, in_range;

    assign wr_en   = cmd.write_ent && (32'(in_reg.slot_index) < TRANS_SLOTS);
    assign wr_slot = PW'(in_reg.slot_index);

    assign ent_wdata.eps_flag = in_reg.eps_flag;
    assign ent_wdata.src      = in_reg.source_node;
    assign ent_wdata.dst      = in_reg.target_node;
    assign ent_wdata.lo       = in_reg.range_low;
    assign ent_wdata.hi       = in_reg.range_high;

    // read address runs one step ahead so the row at ptr_reg is on rdata
    nfa_ram #(.WIDTH($bits(entry_t)), .DEPTH(TRANS_SLOTS)) u_table (
        .aclk, .we(wr_en), .waddr(wr_slot), .wdata(ent_wdata),
        .raddr(ptr_next), .rdata(ent_rdata)
    );

    assign sts.last_slot = (32'(ptr_reg) == TRANS_SLOTS - 1);
    assign sts.changed   = chg_next;

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.clear_acc) ptr_next = '0;
        else if (cmd.step) ptr_next = sts.last_slot ? '0 : ptr_reg + PW'(1);
    end

    assign src_bit  = bit_of(ent_rdata.src);
    assign dst_bit  = bit_of(ent_rdata.dst);
    assign in_range = (ent_rdata.lo <= in_reg.codepoint)
                   && (in_reg.codepoint <= ent_rdata.hi);

    // advance reads the old set, closure reads the growing set
    always_comb begin
        hit = 1'b0;
        if (ent_valid_reg[ptr_reg]) begin
            if (closing_reg) hit = ent_rdata.eps_flag && |(acc_reg & src_bit);
            else hit = !ent_rdata.eps_flag && in_range && |(act_reg & src_bit);
        end
    end

    always_comb begin
        acc_next = acc_reg;
        chg_next = chg_reg;
        if (cmd.step && hit) begin
            acc_next = acc_reg | dst_bit;
            if ((dst_bit & ~acc_reg) != '0) chg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) in_reg <= s_data;
        if (cmd.load_out) begin
            out_reg.accepted <= |(act_reg & bit_of(accept_node));
            out_reg.alive    <= |act_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
            act_reg       <= '0;
            acc_reg       <= '0;
            ptr_reg       <= '0;
            chg_reg       <= 1'b0;
            closing_reg   <= 1'b0;
        end else begin
            if (wr_en) ent_valid_reg[wr_slot] <= in_reg.entry_valid;
            ptr_reg <= ptr_next;
            if (cmd.clear_acc) begin
                chg_reg     <= 1'b0;
                closing_reg <= cmd.seed_start;
                acc_reg     <= cmd.seed_start ? bit_of(start_node) : '0;
            end else if (cmd.step) begin
                acc_reg <= acc_next;
                chg_reg <= sts.last_slot ? 1'b0 : chg_next;
                if (cmd.commit_adv) closing_reg <= 1'b1;
                if (cmd.commit_adv || cmd.commit_clo) act_reg <= acc_next;
            end
        end
    end

    assign m_data = out_reg;
endmodule

>>> design/nfa_regex_full_match_unit.sv
// channel   | direction | handshake             | word
// s_ (in)   | input     | s_valid / s_ready     | in_word_t
// m_ (out)  | output    | m_valid / m_ready     | out_word_t
// cfg_      | input     | cfg_valid / cfg_ready | index + data
// a write or an unused code goes through accept, dispatch and result load
// start seeds the start node, then runs closure rounds, one table entry scanned per cycle
// feed adds one advance pass over all TRANS_SLOTS entries before the closure rounds
// rounds run from 1 to NODE_SLOTS, until a round adds no node
// reset clears all table valid bits at once, no clearing pass
// a stalled result holds the block in its output state
module nfa_regex_full_match_unit
    import nfa_pkg::*;
#(
    parameter int NODE_SLOTS  = NODE_SLOTS_DEF,
    parameter int TRANS_SLOTS = TRANS_SLOTS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [NODE_W-1:0] cfg_data
);
    cmd_t cmd;
    sts_t sts;
    logic [NODE_W-1:0] start_reg, accept_reg;

    // config always accepted
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg  <= '0;
            accept_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_START) start_reg <= cfg_data;
            else accept_reg <= cfg_data;
        end
    end

    nfa_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_action(s_data.action),
        .m_valid, .m_ready, .sts, .cmd
    );

    nfa_dp #(.NODE_SLOTS(NODE_SLOTS), .TRANS_SLOTS(TRANS_SLOTS)) u_dp (
        .aclk, .aresetn, .s_data, .start_node(start_reg), .accept_node(accept_reg),
        .cmd, .sts, .m_data
    );
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

class match_scoreboard;
    logic [53:0] table_q[64];
    logic [31:0] active_set;
    logic [4:0]  start_reg;
    logic [4:0]  accept_reg;
    nfa_pkg::out_word_t expected_q[$];
    int errors;
    int checked;

    function void reset_state();
        foreach (table_q[i]) table_q[i] = '0;
        active_set = '0;
        start_reg = '0;
        accept_reg = '0;
        errors = 0;
        checked = 0;
    endfunction

    function logic [31:0] eps_closure(logic [31:0] s);
        logic [31:0] nxt;
        for (int r = 0; r <= 32; r++) begin
            nxt = s;
            for (int i = 0; i < 64; i++) begin
                // entry layout: valid, eps, src, dst, lo, hi
                if (table_q[i][53] && table_q[i][52] && s[table_q[i][51:47]])
                    nxt[table_q[i][46:42]] = 1'b1;
            end
            if (nxt == s) break;
            s = nxt;
        end
        return s;
    endfunction

    function void note_input(nfa_pkg::in_word_t w);
        logic [31:0] nxt;
        nfa_pkg::out_word_t o;
        nxt = '0;
        case (w.action)
            nfa_pkg::ACT_WRITE: begin
                table_q[w.slot_index] = {w.entry_valid, w.eps_flag, w.source_node,
                                         w.target_node, w.range_low, w.range_high};
            end
            nfa_pkg::ACT_START: begin
                nxt[start_reg] = 1'b1;
                active_set = eps_closure(nxt);
            end
            nfa_pkg::ACT_FEED: begin
                for (int i = 0; i < 64; i++) begin
                    if (table_q[i][53] && !table_q[i][52] && active_set[table_q[i][51:47]]
                        && table_q[i][41:21] <= w.codepoint
                        && w.codepoint <= table_q[i][20:0])
                        nxt[table_q[i][46:42]] = 1'b1;
                end
                active_set = eps_closure(nxt);
            end
            default: ;
        endcase
        o.accepted = active_set[accept_reg];
        o.alive = |active_set;
        expected_q.push_back(o);
    endfunction

    function void check_result(nfa_pkg::out_word_t got);
        nfa_pkg::out_word_t exp_w;
        if (expected_q.size() == 0) begin
            $error("result word with nothing expected: %b", got);
            errors++;
            return;
        end
        exp_w = expected_q.pop_front();
        checked++;
        if (got.accepted !== exp_w.accepted) begin
            $error("accepted: expected %b actual %b", exp_w.accepted, got.accepted);
            errors++;
        end
        if (got.alive !== exp_w.alive) begin
            $error("alive: expected %b actual %b", exp_w.alive, got.alive);
            errors++;
        end
    endfunction
endclass

module tb_top
    import nfa_pkg::*;
();

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_index;
    logic [NODE_W-1:0] cfg_data;

    match_scoreboard sb;
    int  cycle_count = 0;
    int  words_sent;
    bit  calm;             // no idling on either side while set

    localparam int CYCLE_LIMIT = 20_000_000;

    nfa_regex_full_match_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle counter doubles as the watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[nfa_regex_full_match_unit] ERROR");
            $finish;
        end
    end

    // result side: random stalls, checks on every accepted word
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
        end
    end

    // send one word, idling at random beforehand
    task automatic send_word(in_word_t w);
        while (!calm && $urandom_range(0, 99) < 25) @(posedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(w);
        words_sent++;
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for every expected word, then a settle gap before register writes
    task automatic drain();
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_START) sb.start_reg = val;
        else sb.accept_reg = val;
        @(posedge aclk);
    endtask

    function automatic in_word_t blank_word(logic [1:0] act);
        in_word_t w;
        w = '0;
        w.action = act;
        return w;
    endfunction

    task automatic put_entry(logic [5:0] slot, bit eps, logic [4:0] src, logic [4:0] dst,
                             logic [20:0] lo, logic [20:0] hi, bit vld = 1'b1);
        in_word_t w;
        w = blank_word(ACT_WRITE);
        w.slot_index = slot;
        w.entry_valid = vld;
        w.eps_flag = eps;
        w.source_node = src;
        w.target_node = dst;
        w.range_low = lo;
        w.range_high = hi;
        send_word(w);
    endtask

    task automatic feed(logic [20:0] cp);
        in_word_t w;
        w = blank_word(ACT_FEED);
        w.codepoint = cp;
        send_word(w);
    endtask

    // random word of any kind, all bits free
    function automatic in_word_t noise_word();
        in_word_t w;
        w = $bits(in_word_t)'({$urandom, $urandom, $urandom});
        return w;
    endfunction

    // small nfa mostly over nodes 0..n with random ranges, then strings over it
    task automatic random_regex_phase(int words);
        int n;
        int sent0;
        int r;
        in_word_t w;
        n = $urandom_range(2, 10);
        sent0 = words_sent;
        for (int i = 0; i < n * 2; i++) begin
            r = $urandom_range(0, 99);
            w = blank_word(ACT_WRITE);
            w.slot_index = 6'($urandom_range(0, 63));
            w.entry_valid = (r < 92);
            w.eps_flag = (r % 3 == 0);
            w.source_node = 5'($urandom_range(0, n));
            w.target_node = (r < 5) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, n));
            w.range_low = 21'($urandom_range(60, 110));
            w.range_high = (r < 8) ? w.range_low - 21'd1
                                   : w.range_low + 21'($urandom_range(0, 20));
            if (r > 95) begin
                w.range_low = 21'($urandom_range(0, 21'h1FFFFF));
                w.range_high = 21'h1FFFFF;
            end
            if ($urandom_range(0, 9) == 0) w.range_low = w.range_low | 21'($urandom);
            send_word(w);
        end
        while (words_sent - sent0 < words) begin
            r = $urandom_range(0, 99);
            if (r < 12) send_word(blank_word(ACT_START));
            else if (r < 88) feed(21'($urandom_range(55, 135)));
            else if (r < 93) feed(21'($urandom_range(0, 21'h1FFFFF)));
            else send_word(noise_word());
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        words_sent = 0;
        calm = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_START;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: feed before start, reset config, idle code
        feed(21'd97);
        send_word(blank_word(ACT_START));
        send_word(blank_word(ACT_NONE));
        drain();
        write_reg(CFG_START, 5'd1);
        write_reg(CFG_ACCEPT, 5'd31);
        // a(b|c)* style graph: 1 -a-> 2, 2 eps 3, 3 -b..c-> 2, 2 eps 31
        put_entry(0, 0, 1, 2, 97, 97);
        put_entry(1, 1, 2, 3, 21'h1FFFFF, 0);
        put_entry(2, 0, 3, 2, 98, 99);
        put_entry(63, 1, 2, 31, 0, 0);
        put_entry(5, 0, 3, 4, 200, 100);          // empty range
        put_entry(6, 0, 1, 0, 21'h1FFFFF, 21'h1FFFFF);
        send_word(blank_word(ACT_START));
        feed(21'd97);
        feed(21'd98);
        feed(21'd99);
        feed(21'd150);                            // kills the set
        send_word(blank_word(ACT_START));
        feed(21'h1FFFFF);                         // above unicode limit
        put_entry(6, 0, 1, 0, 0, 0, 0);           // clear a slot
        put_entry(7, 1, 31, 1, 0, 0);             // loop back to start
        send_word(blank_word(ACT_START));
        feed(21'd97);
        drain();
        write_reg(CFG_START, 5'd0);
        write_reg(CFG_ACCEPT, 5'd0);
        send_word(blank_word(ACT_START));
        drain();

        // random phases across register settings, one calm stretch
        for (int ph = 0; ph < 20; ph++) begin
            calm = (ph == 7);
            random_regex_phase(50);
            drain();
            write_reg(CFG_START, (ph % 5 == 0) ? 5'd31 : 5'($urandom_range(0, 10)));
            write_reg(CFG_ACCEPT, (ph % 4 == 0) ? 5'd0 : 5'($urandom_range(0, 10)));
        end
        calm = 1'b0;
        drain();
        repeat (200) @(posedge aclk);

        $display("sent %0d input words, checked %0d result words", words_sent, sb.checked);
        $display("covered table writes, starts, feeds, idle codes and both registers");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("[nfa_regex_full_match_unit] OK");
        end else begin
            $display("[nfa_regex_full_match_unit] ERROR");
        end
        $finish;
    end
endmodule
